>>> design/haversine_distance_macros.svh
// ----------------------------------------------------------------------------
// haversine distance assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef HAVERSINE_DISTANCE_MACROS_SVH
`define HAVERSINE_DISTANCE_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define HVD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("haversine_distance: assertion failed");
// expression must never be true
`define HVD_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("haversine_distance: forbidden condition seen");
`else
`define HVD_ASSERT(lbl, prop)
`define HVD_NEVER(lbl, expr)
`endif
`endif

>>> design/hvd_pkg.sv
// ----------------------------------------------------------------------------
// hvd_pkg
// shared constants, CORDIC arctangent table and datapath types
// ----------------------------------------------------------------------------
package hvd_pkg;

    // default number of CORDIC iterations
    localparam int CORDIC_STEPS_DEF = 32;
    // iterations of the digit-by-digit square root
    localparam int ISQ_STEPS = 32;

    // CORDIC working word, wide enough for x, y and z in every iteration
    localparam int CW = 36;
    typedef logic signed [CW-1:0] cord_t;

    // CORDIC gain in Q30
    localparam cord_t GAIN_Q30 = 36'sd652032874;
    // 1e-7 degree to binary turns scale (Q30)
    localparam logic signed [64:0] DEG7_TURN_K = 65'sd1281023894;
    // pi in Q32
    localparam logic [64:0] PI_Q32 = 65'd13493037705;
    // one in Q30
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    // output saturation level
    localparam logic [31:0] DIST_MAX = 32'd2200000000;
    // radius register reset, and the same already scaled to centimetres
    localparam logic [22:0] RADIUS_RESET = 23'd6367000;
    localparam logic [29:0] R100_RESET = 30'd636700000;

    // atan(2^-i) in turns of 2^32
    localparam logic [29:0] ATAN_TURNS [32] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5,
        30'd3,         30'd1,         30'd1,         30'd0
    };

    // rotation angle of one iteration, zero past the table
    function automatic cord_t step_angle(input int i);
        cord_t r;
        r = '0;
        if (i < 32)
        begin
            r = cord_t'({1'b0, ATAN_TURNS[i[4:0]]});
        end
        return r;
    endfunction

endpackage

>>> design/haversine_distance.sv
// ----------------------------------------------------------------------------
// haversine_distance
// great-circle distance of two lat/lon points, haversine formula, pipelined
// ----------------------------------------------------------------------------
//  channel  | signals                            | direction
//  in       | in_valid in_ready lat/lon a and b  | request in
//  out      | out_valid out_ready distance_cm    | request out
//  cfg      | cfg_valid cfg_ready cfg_data       | radius write in
//
//  one request enters per cycle while in_ready is high; the path from input
//  accept to output accept runs through the two CORDIC chains, the 32-stage
//  square root and the output register
//  reset clears the stage valid bits, the output stages and the radius
//  (6367000 m); there is no clearing pass
//  the pipeline advances while the skid register is empty, so a request is
//  still taken while a result waits in the output register
// ----------------------------------------------------------------------------
`include "haversine_distance_macros.svh"

module haversine_distance
    import hvd_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [30:0]  lat_a,
    input  logic signed [31:0]  lon_a,
    input  logic signed [30:0]  lat_b,
    input  logic signed [31:0]  lon_b,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         distance_cm,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [22:0]         cfg_data
);

    localparam int LAT = 2 * CORDIC_STEPS + 41;

    logic                en;
    logic [LAT-1:0]      vld_reg;
    logic [29:0]         r100_reg;

    logic signed [30:0]  la_reg;
    logic signed [30:0]  lb_reg;
    logic signed [31:0]  dlat_reg;
    logic signed [32:0]  dlon_reg;

    logic [31:0]         t_la_reg;
    logic [31:0]         t_lb_reg;
    logic [31:0]         t_dlat_reg;
    logic [31:0]         t_dlon_reg;
    logic signed [64:0]  p_la;
    logic signed [64:0]  p_lb;
    logic signed [64:0]  p_dlat;
    logic signed [64:0]  p_dlon;

    logic signed [31:0]  s1;
    logic signed [31:0]  s2;
    logic signed [31:0]  c1;
    logic signed [31:0]  c2;

    logic signed [63:0]  m_sq1;
    logic signed [63:0]  m_sq2;
    logic signed [63:0]  m_c12;
    logic signed [32:0]  sq1_reg;
    logic signed [32:0]  sq2_reg;
    logic signed [32:0]  c12_reg;
    logic signed [65:0]  m_t;
    logic signed [32:0]  sq1d_reg;
    logic signed [35:0]  t_reg;
    logic signed [36:0]  a_sum;
    logic [30:0]         a_clamp;
    logic [30:0]         a_reg;
    logic [30:0]         b_reg;

    logic [30:0]         ya;
    logic [30:0]         xa;
    cord_t               z;
    logic [30:0]         z_clamp;
    logic [64:0]         m_cq;
    logic [34:0]         cq_reg;
    logic [64:0]         m_d;
    logic [31:0]         d_sat;
    logic [31:0]         pd_reg;

    logic                out_valid_reg;
    logic [31:0]         out_data_reg;
    logic                skid_valid_reg;
    logic [31:0]         skid_data_reg;
    logic                p_valid;
    logic                push;
    logic                take;

    // pipeline enable and handshakes
    assign en        = !skid_valid_reg;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;
    assign p_valid   = vld_reg[LAT-1];
    assign push      = en && p_valid;
    assign take      = out_valid_reg && out_ready;

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // radius register, kept scaled to centimetres
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r100_reg <= R100_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            r100_reg <= 30'({7'b0, cfg_data} * 30'd100);
        end
    end

    // input capture and coordinate differences
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            la_reg   <= lat_a;
            lb_reg   <= lat_b;
            dlat_reg <= 32'(lat_b) - 32'(lat_a);
            dlon_reg <= 33'(lon_b) - 33'(lon_a);
        end
    end

    // conversion to binary turns
    always_comb
    begin
        p_la   = 65'(la_reg) * DEG7_TURN_K + 65'sd536870912;
        p_lb   = 65'(lb_reg) * DEG7_TURN_K + 65'sd536870912;
        p_dlat = 65'(dlat_reg) * DEG7_TURN_K + 65'sd536870912;
        p_dlon = 65'(dlon_reg) * DEG7_TURN_K + 65'sd536870912;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_la_reg   <= p_la[61:30];
            t_lb_reg   <= p_lb[61:30];
            t_dlat_reg <= p_dlat[61:30];
            t_dlon_reg <= p_dlon[61:30];
        end
    end

    // sines of the half differences, cosines of the latitudes
    hvd_sincos #(.STEPS(CORDIC_STEPS)) u_sin_dlat (
        .clk(clk), .en(en), .ang({1'b0, t_dlat_reg[31:1]}), .want_cos(1'b0), .value(s1)
    );
    hvd_sincos #(.STEPS(CORDIC_STEPS)) u_sin_dlon (
        .clk(clk), .en(en), .ang({1'b0, t_dlon_reg[31:1]}), .want_cos(1'b0), .value(s2)
    );
    hvd_sincos #(.STEPS(CORDIC_STEPS)) u_cos_la (
        .clk(clk), .en(en), .ang(t_la_reg), .want_cos(1'b1), .value(c1)
    );
    hvd_sincos #(.STEPS(CORDIC_STEPS)) u_cos_lb (
        .clk(clk), .en(en), .ang(t_lb_reg), .want_cos(1'b1), .value(c2)
    );

    // first products in Q30
    always_comb
    begin
        m_sq1 = 64'(s1) * 64'(s1);
        m_sq2 = 64'(s2) * 64'(s2);
        m_c12 = 64'(c1) * 64'(c2);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq1_reg <= 33'(m_sq1 >>> 30);
            sq2_reg <= 33'(m_sq2 >>> 30);
            c12_reg <= 33'(m_c12 >>> 30);
        end
    end

    // second product
    assign m_t = 66'(c12_reg) * 66'(sq2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq1d_reg <= sq1_reg;
            t_reg    <= 36'(m_t >>> 30);
        end
    end

    // haversine term, clamped to [0, 1]
    always_comb
    begin
        a_sum = 37'(sq1d_reg) + 37'(t_reg);
        if (a_sum < 0)
        begin
            a_clamp = '0;
        end
        else if (a_sum > 37'(ONE_Q30))
        begin
            a_clamp = ONE_Q30;
        end
        else
        begin
            a_clamp = a_sum[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_clamp;
            b_reg <= ONE_Q30 - a_clamp;
        end
    end

    // square roots of a and 1 - a
    hvd_isqrt u_sqrt_a (
        .clk(clk), .en(en), .radicand({a_reg, 30'b0}), .root(ya)
    );
    hvd_isqrt u_sqrt_b (
        .clk(clk), .en(en), .radicand({b_reg, 30'b0}), .root(xa)
    );

    // central half angle
    hvd_atan2 #(.STEPS(CORDIC_STEPS)) u_atan2 (
        .clk(clk), .en(en), .y_in(ya), .x_in(xa), .angle(z)
    );

    // angle to radians in Q32
    always_comb
    begin
        if (z < 0)
        begin
            z_clamp = '0;
        end
        else if (z > cord_t'(ONE_Q30))
        begin
            z_clamp = ONE_Q30;
        end
        else
        begin
            z_clamp = z[30:0];
        end
        m_cq = 65'(z_clamp) * PI_Q32;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cq_reg <= m_cq[64:30];
        end
    end

    // scale by radius, round and saturate
    always_comb
    begin
        m_d = 65'(cq_reg) * 65'(r100_reg) + 65'h0_8000_0000;
        if (m_d[64:32] > 33'(DIST_MAX))
        begin
            d_sat = DIST_MAX;
        end
        else
        begin
            d_sat = m_d[63:32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pd_reg <= d_sat;
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take || !out_valid_reg)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : pd_reg;
        end
        else if (push)
        begin
            skid_data_reg <= pd_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign distance_cm = out_data_reg;

    // checks
    `HVD_ASSERT(a_skid_needs_out, skid_valid_reg |-> out_valid_reg)
    `HVD_ASSERT(a_dist_sat, out_valid_reg |-> out_data_reg <= DIST_MAX)
    `HVD_ASSERT(a_entry_tracked, in_valid && in_ready |=> vld_reg[0])
    `HVD_NEVER(a_skid_blocks_in, skid_valid_reg && in_ready)

endmodule

>>> design/hvd_sincos.sv
// ----------------------------------------------------------------------------
// hvd_sincos
// pipelined rotation-mode CORDIC, one iteration per register stage
// ----------------------------------------------------------------------------
module hvd_sincos
    import hvd_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                clk,
    input  logic                en,
    input  logic [31:0]         ang,
    input  logic                want_cos,
    output logic signed [31:0]  value
);

    cord_t      x_reg [STEPS+1];
    cord_t      y_reg [STEPS+1];
    cord_t      z_reg [STEPS+1];
    logic [1:0] q_reg [STEPS+1];
    logic signed [31:0] value_reg;
    logic [1:0]  q;
    logic [31:0] ru;
    logic [31:0] ang_rnd;

    // quadrant reduction to [-45, 45) degrees
    always_comb
    begin
        ang_rnd = ang + 32'h2000_0000;
        q       = ang_rnd[31:30];
        ru      = ang - {q, 30'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= GAIN_Q30;
            y_reg[0] <= '0;
            z_reg[0] <= cord_t'($signed(ru));
            q_reg[0] <= q;
        end
    end

    // iteration stages
    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - step_angle(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + step_angle(i);
                end
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    // quadrant restore and output select
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            case (q_reg[STEPS])
                2'd0:
                    value_reg <= want_cos ? 32'(x_reg[STEPS]) : 32'(y_reg[STEPS]);
                2'd1:
                    value_reg <= want_cos ? 32'(-y_reg[STEPS]) : 32'(x_reg[STEPS]);
                2'd2:
                    value_reg <= want_cos ? 32'(-x_reg[STEPS]) : 32'(-y_reg[STEPS]);
                default:
                    value_reg <= want_cos ? 32'(y_reg[STEPS]) : 32'(-x_reg[STEPS]);
            endcase
        end
    end

    assign value = value_reg;

endmodule

>>> design/hvd_isqrt.sv
// ----------------------------------------------------------------------------
// hvd_isqrt
// pipelined digit-by-digit integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module hvd_isqrt
    import hvd_pkg::*;
(
    input  logic         clk,
    input  logic         en,
    input  logic [60:0]  radicand,
    output logic [30:0]  root
);

    logic [63:0] v_reg [1:ISQ_STEPS];
    logic [63:0] r_reg [1:ISQ_STEPS];

    for (genvar k = 0; k < ISQ_STEPS; k++)
    begin : g_digit
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] v_cur;
        logic [63:0] r_cur;
        logic [63:0] trial;

        if (k == 0)
        begin : g_first
            assign v_cur = {3'b0, radicand};
            assign r_cur = '0;
        end
        else
        begin : g_next
            assign v_cur = v_reg[k];
            assign r_cur = r_reg[k];
        end

        assign trial = r_cur + BIT;

        // try the next root bit
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (v_cur >= trial)
                begin
                    v_reg[k+1] <= v_cur - trial;
                    r_reg[k+1] <= (r_cur >> 1) + BIT;
                end
                else
                begin
                    v_reg[k+1] <= v_cur;
                    r_reg[k+1] <= r_cur >> 1;
                end
            end
        end
    end

    assign root = r_reg[ISQ_STEPS][30:0];

endmodule

>>> design/hvd_atan2.sv
// ----------------------------------------------------------------------------
// hvd_atan2
// pipelined vectoring-mode CORDIC giving atan2(y, x) in binary turns
// ----------------------------------------------------------------------------
module hvd_atan2
    import hvd_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
)
(
    input  logic         clk,
    input  logic         en,
    input  logic [30:0]  y_in,
    input  logic [30:0]  x_in,
    output cord_t        angle
);

    cord_t x_reg [1:STEPS];
    cord_t y_reg [1:STEPS];
    cord_t z_reg [1:STEPS];

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        cord_t x_cur;
        cord_t y_cur;
        cord_t z_cur;

        if (i == 0)
        begin : g_first
            assign x_cur = cord_t'({1'b0, x_in});
            assign y_cur = cord_t'({1'b0, y_in});
            assign z_cur = '0;
        end
        else
        begin : g_next
            assign x_cur = x_reg[i];
            assign y_cur = y_reg[i];
            assign z_cur = z_reg[i];
        end

        // rotate toward the x axis
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_cur >= 0)
                begin
                    x_reg[i+1] <= x_cur + (y_cur >>> i);
                    y_reg[i+1] <= y_cur - (x_cur >>> i);
                    z_reg[i+1] <= z_cur + step_angle(i);
                end
                else
                begin
                    x_reg[i+1] <= x_cur - (y_cur >>> i);
                    y_reg[i+1] <= y_cur + (x_cur >>> i);
                    z_reg[i+1] <= z_cur - step_angle(i);
                end
            end
        end
    end

    assign angle = z_reg[STEPS];

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks haversine_distance against a bit-exact predictor of the fixed-point
// CORDIC and square-root datapath, over directed points, radius settings
// and a long random stream, with random gaps on both handshake channels
// ----------------------------------------------------------------------------
module tb;
    import hvd_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;
    logic               out_valid;
    logic               out_ready;
    logic [31:0]        distance_cm;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [22:0]        cfg_data;

    localparam int LATENCY = 2 * CORDIC_STEPS_DEF + 41;
    localparam int STALL_LIMIT = 4000;

    logic [22:0] radius_m;
    logic [31:0] dist_q[$];
    int          errors;
    int          sent;
    int          checked;
    int          radius_writes;
    int          quiet_cycles;
    bit          no_idle;

    haversine_distance dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .lat_a       (lat_a),
        .lon_a       (lon_a),
        .lat_b       (lat_b),
        .lon_b       (lon_b),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .distance_cm (distance_cm),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // 1e-7 degree to binary turns
    function automatic logic [31:0] deg7_to_turns(input longint d);
        logic [63:0] p;
        p = d;
        p = p * 64'd1281023894 + 64'd536870912;
        return p[61:30];
    endfunction

    // CORDIC rotation: sine and cosine of an angle in turns, Q30
    function automatic void sin_cos(input logic [31:0] ang, output longint s,
                                    output longint c);
        logic [31:0] q;
        logic [31:0] ru;
        longint      z;
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        longint      step;
        int          sh;
        q = ((ang + 32'h2000_0000) >> 30) & 32'd3;
        ru = ang - (q << 30);
        z = signed'(ru);
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS_DEF; i++)
        begin
            sh = (i < 62) ? i : 62;
            step = (i < 32) ? longint'(ATAN_TURNS[i]) : 0;
            dx = y >>> sh;
            dy = x >>> sh;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= step;
            end
            else
            begin
                x += dx; y -= dy; z += step;
            end
        end
        case (q)
            0: begin s = y;  c = x;  end
            1: begin s = x;  c = -y; end
            2: begin s = -y; c = -x; end
            default: begin s = -x; c = y; end
        endcase
    endfunction

    // digit-by-digit integer square root
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
            begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    // full distance prediction for one point pair
    function automatic logic [31:0] great_circle_cm(input longint la,
        input longint oa, input longint lb, input longint ob,
        input logic [22:0] rad);
        longint      s1, s2, c1, c2, dummy, hav, x, y, z, dx, dy, step;
        logic [63:0] ya, xa, cq, d, r100;
        int          sh;
        sin_cos(deg7_to_turns(lb - la) >> 1, s1, dummy);
        sin_cos(deg7_to_turns(ob - oa) >> 1, s2, dummy);
        sin_cos(deg7_to_turns(la), dummy, c1);
        sin_cos(deg7_to_turns(lb), dummy, c2);
        hav = q30_mul(s1, s1) + q30_mul(q30_mul(c1, c2), q30_mul(s2, s2));
        if (hav < 0) hav = 0;
        if (hav > (64'sd1 << 30)) hav = 64'sd1 << 30;
        ya = hav;
        xa = (64'sd1 << 30) - hav;
        ya = int_sqrt(ya << 30);
        xa = int_sqrt(xa << 30);
        // CORDIC vectoring for the central angle
        y = ya;
        x = xa;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS_DEF; i++)
        begin
            sh = (i < 62) ? i : 62;
            step = (i < 32) ? longint'(ATAN_TURNS[i]) : 0;
            dx = y >>> sh;
            dy = x >>> sh;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += step;
            end
            else
            begin
                x -= dx; y += dy; z -= step;
            end
        end
        if (z < 0) z = 0;
        if (z > (64'sd1 << 30)) z = 64'sd1 << 30;
        cq = z;
        cq = (cq * 64'd13493037705) >> 30;
        r100 = rad;
        r100 = r100 * 64'd100;
        d = (cq * r100 + (64'd1 << 31)) >> 32;
        if (d > 64'd2200000000) d = 64'd2200000000;
        return d[31:0];
    endfunction

    // send one request, random gap before it unless in a burst stretch
    task automatic send_points(input longint la, input longint oa,
                               input longint lb, input longint ob);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        lat_a <= la[30:0];
        lon_a <= oa[31:0];
        lat_b <= lb[30:0];
        lon_b <= ob[31:0];
        do @(posedge clk); while (!in_ready);
        dist_q.push_back(great_circle_cm(longint'(signed'(la[30:0])),
            longint'(signed'(oa[31:0])), longint'(signed'(lb[30:0])),
            longint'(signed'(ob[31:0])), radius_m));
        sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (dist_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_radius(input logic [22:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        radius_m = v;
        radius_writes++;
    endtask

    // random point pair: mostly in range, some near each other, some raw bits
    task automatic send_random();
        longint la, oa, lb, ob;
        int     kind;
        kind = $urandom_range(0, 7);
        la = longint'($urandom_range(0, 1800000000)) - 900000000;
        oa = longint'($urandom_range(0, 3600000000)) - 1800000000;
        lb = longint'($urandom_range(0, 1800000000)) - 900000000;
        ob = longint'($urandom_range(0, 3600000000)) - 1800000000;
        if (kind < 2)
        begin
            lb = la + longint'($urandom_range(0, 20000)) - 10000;
            ob = oa + longint'($urandom_range(0, 20000)) - 10000;
        end
        else if (kind == 7)
        begin
            la = signed'($urandom());
            oa = signed'($urandom());
            lb = signed'($urandom());
            ob = signed'($urandom());
        end
        send_points(la, oa, lb, ob);
    endtask

    // extremes, poles, antipodes, identical points, wrapped coordinates
    task automatic test_directed();
        send_points(0, 0, 0, 0);
        send_points(900000000, 0, -900000000, 0);
        send_points(0, 0, 0, 1800000000);
        send_points(0, -1800000000, 0, 1800000000);
        send_points(0, 0, 0, -1800000000);
        send_points(900000000, 1800000000, 900000000, -1800000000);
        send_points(-900000000, 0, -900000000, 1234567);
        send_points(515000000, -1200000, 488500000, 23500000);
        send_points(123456789, 987654321, 123456789, 987654321);
        send_points(0, 0, 1, 1);
        send_points(-1073741824, -2147483648, 1073741823, 2147483647);
        send_points(1073741823, 2147483647, -1073741824, -2147483648);
        send_points(1073741823, 0, 1073741823, 0);
        send_points(-1073741824, 2147483647, 0, 0);
        send_points(0, 2147483647, 0, -2147483648);
        send_points(450000000, 900000000, -450000000, -900000000);
        send_points(300000000, 0, -300000000, 1800000000);
        send_points(-1, -1, 0, 0);
    endtask

    // radius extremes and register reach, a few items per setting
    task automatic test_radius();
        logic [22:0] vals [5] = '{23'd6000000, 23'd7000000, 23'h7FFFFF,
                                  23'd0, 23'd6367000};
        foreach (vals[i])
        begin
            write_radius(vals[i]);
            send_points(0, 0, 0, 1800000000);
            send_points(900000000, 0, -900000000, 0);
            for (int k = 0; k < 20; k++) send_random();
        end
    endtask

    // long random stream with burst and idle stretches
    task automatic test_random_stream(input int n);
        for (int k = 0; k < n; k++)
        begin
            if (k % 64 == 0) no_idle = ($urandom_range(0, 2) == 0);
            send_random();
        end
        no_idle = 1'b0;
    endtask

    // sender holds off until the pipeline is empty, then resumes
    task automatic test_drain_pause();
        for (int k = 0; k < 40; k++) send_random();
        wait_drained();
        for (int k = 0; k < 40; k++) send_random();
    endtask

    // result side: random stall before each result
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // compare each result with the oldest expected distance
    always @(posedge clk)
    begin
        logic [31:0] exp_cm;
        if (rst_n && out_valid && out_ready)
        begin
            if (dist_q.size() == 0)
            begin
                $display("%0t: unexpected result distance_cm=%0d", $time,
                         distance_cm);
                errors++;
            end
            else
            begin
                exp_cm = dist_q.pop_front();
                checked++;
                if (distance_cm !== exp_cm)
                begin
                    $display("%0t: distance_cm expected %0d actual %0d", $time,
                             exp_cm, distance_cm);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready) || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout with %0d results outstanding", dist_q.size());
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // sequence of tests
    initial
    begin
        errors = 0;
        sent = 0;
        checked = 0;
        radius_writes = 0;
        quiet_cycles = 0;
        no_idle = 1'b0;
        radius_m = RADIUS_RESET;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        lat_a <= '0;
        lon_a <= '0;
        lat_b <= '0;
        lon_b <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_radius();
        test_drain_pause();
        write_radius(23'd6371000);
        test_random_stream(1700);
        wait_drained();
        repeat (LATENCY + 20) @(posedge clk);
        $display("sent %0d point pairs, checked %0d distances, %0d radius writes",
                 sent, checked, radius_writes);
        $display("covered extremes, wrapped angles, radius limits, stalls, drain");
        if (errors == 0 && dist_q.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
